/* design/rmth_pkg.sv */
// Shared types, constants and helpers for the running-median block.
// Used by running_median_two_heaps; depends on nothing else.
`timescale 1ns / 1ps

package rmth_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int MEDIAN_WIDTH     = SAMPLE_WIDTH + 1;
    localparam int COUNT_WIDTH      = 11;
    localparam int CAPACITY_DEFAULT = 1024;

    // Heap selector codes
    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           start_new;
    } t_in_beat;

    typedef struct packed {
        logic signed [MEDIAN_WIDTH-1:0] median_doubled;
        logic [COUNT_WIDTH-1:0]         sample_count;
        logic                           rejected_full;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_REP_RD,
        S_REP_CMP,
        S_DONE,
        S_OUT
    } t_state;

    // True when a belongs nearer the top than b: larger for the lower
    // (max) heap, smaller for the upper (min) heap.
    function automatic logic heap_better(
        input logic                           heap,
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b
    );
        logic res;
        res = (heap == HEAP_UPPER) ? (a < b) : (a > b);
        return res;
    endfunction

endpackage

/* design/running_median_two_heaps.sv */
// Running median of a signed sample stream kept in two heaps in block RAM.
// Depends on rmth_pkg for beat types, the state enum and the heap compare.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one sample
//   and a start flag per beat. Output channel (o_out_valid / i_out_stall /
//   o_out_data) returns one beat per input: twice the median of the samples
//   held, the number held and a reject flag.
//   One item at a time: o_in_stall stays high from acceptance until its
//   result beat has been taken. Each item runs one heap insert and, when the
//   halves must be rebalanced, one replace-top, on a single sequencer.
//   Every heap level takes a RAM read state, then a compare-and-write state.
//   A rejected sample (store full, no start flag) skips the heap steps and
//   repeats the previous median.
//   Reset clears both counts and the held median; the heap RAMs are not
//   cleared since only entries below the counts are ever read.
//   While the receiver stalls, the result beat holds and no input is taken.
module running_median_two_heaps #(
    parameter int CAPACITY = rmth_pkg::CAPACITY_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rmth_pkg::t_in_beat i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rmth_pkg::t_out_beat o_out_data
);

    localparam int SW         = rmth_pkg::SAMPLE_WIDTH;
    localparam int MW         = rmth_pkg::MEDIAN_WIDTH;
    localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
    localparam int AW         = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int NW         = $clog2(HEAP_DEPTH + 1);
    localparam int PW         = NW + 1;
    localparam int TW         = $clog2(CAPACITY + 1) + 1;

    // Heap storage
    logic signed [SW-1:0] ram_lo [HEAP_DEPTH];
    logic signed [SW-1:0] ram_up [HEAP_DEPTH];
    logic signed [SW-1:0] r_lo_a, r_lo_b, r_up_a, r_up_b;

    // Sequencer state
    rmth_pkg::t_state     r_state, n_state;
    logic [NW-1:0]        r_lc, n_lc, r_uc, n_uc;
    logic signed [SW-1:0] r_ltop, n_ltop, r_utop, n_utop;
    logic signed [MW-1:0] r_last, n_last;
    logic                 r_rej, n_rej;
    logic                 r_op_heap, n_op_heap;
    logic signed [SW-1:0] r_op_val, n_op_val;
    logic [NW-1:0]        r_op_n, n_op_n;
    logic                 r_op2_vld, n_op2_vld;
    logic                 r_op2_heap, n_op2_heap;
    logic signed [SW-1:0] r_op2_val, n_op2_val;
    logic [NW-1:0]        r_op2_n, n_op2_n;
    logic [PW-1:0]        r_pos, n_pos;
    rmth_pkg::t_out_beat  r_out, n_out;

    // RAM access
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic signed [SW-1:0] mem_wd;
    logic [PW-1:0]        rd_a, rd_b;

    // Working values
    logic [NW-1:0]        elc, euc;
    logic [TW-1:0]        tot;
    logic [PW-1:0]        par, lch, rch;
    logic signed [SW-1:0] rd_x, rd_y, cv;
    logic [PW-1:0]        cpos;
    logic                 fin;

    // Write and read the lower heap
    always_ff @(posedge i_clk) begin
        if (mem_we && r_op_heap == rmth_pkg::HEAP_LOWER) begin
            ram_lo[mem_wa] <= mem_wd;
        end
        r_lo_a <= ram_lo[rd_a[AW-1:0]];
        r_lo_b <= ram_lo[rd_b[AW-1:0]];
    end

    // Write and read the upper heap
    always_ff @(posedge i_clk) begin
        if (mem_we && r_op_heap == rmth_pkg::HEAP_UPPER) begin
            ram_up[mem_wa] <= mem_wd;
        end
        r_up_a <= ram_up[rd_a[AW-1:0]];
        r_up_b <= ram_up[rd_b[AW-1:0]];
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rmth_pkg::S_IDLE;
            r_lc      <= '0;
            r_uc      <= '0;
            r_last    <= '0;
            r_op2_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lc      <= n_lc;
            r_uc      <= n_uc;
            r_last    <= n_last;
            r_op2_vld <= n_op2_vld;
        end
        r_ltop     <= n_ltop;
        r_utop     <= n_utop;
        r_rej      <= n_rej;
        r_op_heap  <= n_op_heap;
        r_op_val   <= n_op_val;
        r_op_n     <= n_op_n;
        r_op2_heap <= n_op2_heap;
        r_op2_val  <= n_op2_val;
        r_op2_n    <= n_op2_n;
        r_pos      <= n_pos;
        r_out      <= n_out;
    end

    // Next state, RAM control and outputs
    always_comb begin
        n_state    = r_state;
        n_lc       = r_lc;
        n_uc       = r_uc;
        n_ltop     = r_ltop;
        n_utop     = r_utop;
        n_last     = r_last;
        n_rej      = r_rej;
        n_op_heap  = r_op_heap;
        n_op_val   = r_op_val;
        n_op_n     = r_op_n;
        n_op2_vld  = r_op2_vld;
        n_op2_heap = r_op2_heap;
        n_op2_val  = r_op2_val;
        n_op2_n    = r_op2_n;
        n_pos      = r_pos;
        n_out      = r_out;
        mem_we     = 1'b0;
        mem_wa     = r_pos[AW-1:0];
        mem_wd     = r_op_val;
        fin        = 1'b0;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;

        par  = (r_pos - PW'(1)) >> 1;
        lch  = {r_pos[PW-2:0], 1'b1};
        rch  = lch + PW'(1);
        rd_a = r_pos;
        rd_b = r_pos;
        rd_x = (r_op_heap == rmth_pkg::HEAP_UPPER) ? r_up_a : r_lo_a;
        rd_y = (r_op_heap == rmth_pkg::HEAP_UPPER) ? r_up_b : r_lo_b;
        elc  = i_in_data.start_new ? '0 : r_lc;
        euc  = i_in_data.start_new ? '0 : r_uc;
        tot  = TW'(elc) + TW'(euc);
        cv   = rd_x;
        cpos = lch;

        unique case (r_state)
            rmth_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_op_heap = rmth_pkg::HEAP_LOWER;
                    n_op_val  = i_in_data.sample;
                    n_op_n    = elc;
                    n_pos     = PW'(elc);
                    n_op2_vld = 1'b0;
                    n_op2_val = i_in_data.sample;
                    n_lc      = elc;
                    n_uc      = euc;
                    n_rej     = 1'b0;
                    n_state   = rmth_pkg::S_PUSH_RD;
                    priority if (tot >= TW'(CAPACITY)) begin
                        n_rej   = 1'b1;
                        n_state = rmth_pkg::S_DONE;
                    end else if (elc == '0) begin
                        n_lc = elc + NW'(1);
                    end else if (elc == euc) begin
                        n_lc = elc + NW'(1);
                        if (!(i_in_data.sample <= r_ltop || i_in_data.sample <= r_utop)) begin
                            // Upper top moves down, sample replaces it
                            n_op_val   = r_utop;
                            n_op2_vld  = 1'b1;
                            n_op2_heap = rmth_pkg::HEAP_UPPER;
                            n_op2_n    = euc;
                        end
                    end else begin
                        n_uc      = euc + NW'(1);
                        n_op_heap = rmth_pkg::HEAP_UPPER;
                        n_op_n    = euc;
                        n_pos     = PW'(euc);
                        if (i_in_data.sample <= r_ltop) begin
                            // Lower top moves up, sample replaces it
                            n_op_val   = r_ltop;
                            n_op2_vld  = 1'b1;
                            n_op2_heap = rmth_pkg::HEAP_LOWER;
                            n_op2_n    = elc;
                        end
                    end
                end
            end
            rmth_pkg::S_PUSH_RD: begin
                rd_a = par;
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                    fin    = 1'b1;
                end else begin
                    n_state = rmth_pkg::S_PUSH_CMP;
                end
            end
            rmth_pkg::S_PUSH_CMP: begin
                mem_we = 1'b1;
                if (rmth_pkg::heap_better(r_op_heap, r_op_val, rd_x)) begin
                    // Pull the parent down and climb
                    mem_wd  = rd_x;
                    n_pos   = par;
                    n_state = rmth_pkg::S_PUSH_RD;
                end else begin
                    fin = 1'b1;
                end
            end
            rmth_pkg::S_REP_RD: begin
                rd_a = lch;
                rd_b = rch;
                if (lch >= PW'(r_op_n)) begin
                    mem_we = 1'b1;
                    fin    = 1'b1;
                end else begin
                    n_state = rmth_pkg::S_REP_CMP;
                end
            end
            rmth_pkg::S_REP_CMP: begin
                if (rch < PW'(r_op_n) && rmth_pkg::heap_better(r_op_heap, rd_y, rd_x)) begin
                    cv   = rd_y;
                    cpos = rch;
                end
                mem_we = 1'b1;
                if (rmth_pkg::heap_better(r_op_heap, cv, r_op_val)) begin
                    // Lift the better child and descend
                    mem_wd  = cv;
                    n_pos   = cpos;
                    n_state = rmth_pkg::S_REP_RD;
                end else begin
                    fin = 1'b1;
                end
            end
            rmth_pkg::S_DONE: begin
                if (!r_rej) begin
                    if (r_lc == r_uc) begin
                        n_last = {r_ltop[SW-1], r_ltop} + {r_utop[SW-1], r_utop};
                    end else begin
                        n_last = {r_ltop, 1'b0};
                    end
                end
                n_out.median_doubled = r_rej ? r_last : n_last;
                n_out.sample_count   = rmth_pkg::COUNT_WIDTH'(TW'(r_lc) + TW'(r_uc));
                n_out.rejected_full  = r_rej;
                n_state = rmth_pkg::S_OUT;
            end
            rmth_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = rmth_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmth_pkg::S_IDLE;
            end
        endcase

        // Track the tops of both heaps
        if (mem_we && mem_wa == '0 && r_pos == '0) begin
            if (r_op_heap == rmth_pkg::HEAP_UPPER) begin
                n_utop = mem_wd;
            end else begin
                n_ltop = mem_wd;
            end
        end

        // Chain to the replace-top or finish
        if (fin) begin
            if (r_op2_vld) begin
                n_op2_vld = 1'b0;
                n_op_heap = r_op2_heap;
                n_op_val  = r_op2_val;
                n_op_n    = r_op2_n;
                n_pos     = '0;
                n_state   = rmth_pkg::S_REP_RD;
            end else begin
                n_state = rmth_pkg::S_DONE;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

/* verif/running_median_two_heaps_chk.sv */
// Checker for running_median_two_heaps: watches both channels, predicts each
// result from a sorted copy of the held samples and compares field by field.
// Depends on rmth_pkg for the beat types and widths.
`timescale 1ns / 1ps

module running_median_two_heaps_chk
    import rmth_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_rejects
);

    // Held samples in ascending order; the two heap tops sit at the middle.
    logic signed [SAMPLE_WIDTH-1:0] held_sorted[$];
    logic signed [MEDIAN_WIDTH-1:0] held_median;
    t_out_beat                      median_fifo[$];

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    // Advance the predicted store by one sample and return its result beat.
    function automatic t_out_beat median_step(input t_in_beat b);
        t_out_beat r;
        int        n;
        int        pos;
        if (b.start_new) begin
            held_sorted.delete();
        end
        r.rejected_full = (held_sorted.size() >= CAPACITY);
        if (!r.rejected_full) begin
            pos = 0;
            while (pos < held_sorted.size() && held_sorted[pos] <= b.sample) pos++;
            held_sorted.insert(pos, b.sample);
            n = held_sorted.size();
            held_median = MEDIAN_WIDTH'(held_sorted[(n - 1) / 2])
                        + MEDIAN_WIDTH'(held_sorted[n / 2]);
        end
        r.median_doubled = held_median;
        r.sample_count   = COUNT_WIDTH'(held_sorted.size());
        return r;
    endfunction

    // Predict on each input beat, compare on each output beat.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            held_sorted.delete();
            median_fifo.delete();
            held_median = '0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                median_fifo.insert(median_fifo.size(), median_step(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (median_fifo.size() == 0) begin
                    report("unexpected result beat", 0, 0);
                end else begin
                    want = median_fifo.pop_front();
                    if (want.rejected_full) o_rejects++;
                    if (i_out_data.median_doubled !== want.median_doubled)
                        report("median_doubled", i_out_data.median_doubled,
                               want.median_doubled);
                    if (i_out_data.sample_count !== want.sample_count)
                        report("sample_count", i_out_data.sample_count,
                               want.sample_count);
                    if (i_out_data.rejected_full !== want.rejected_full)
                        report("rejected_full", i_out_data.rejected_full,
                               want.rejected_full);
                end
            end
        end
        o_pending = median_fifo.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_rejects = 0;
    end

endmodule

/* verif/running_median_two_heaps_tb.sv */
// Testbench top for running_median_two_heaps: drives samples with random
// gaps and output stalls, fills the store past capacity, and gives the verdict.
// Depends on rmth_pkg, running_median_two_heaps and running_median_two_heaps_chk.
`timescale 1ns / 1ps

module running_median_two_heaps_tb;
    import rmth_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEFAULT;
    localparam int ITEM_TOTAL = 1950;
    localparam int QUIET_FROM = 1750;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      r_in_valid;
    t_in_beat  r_in_data;
    logic      w_in_stall;
    logic      w_out_valid;
    logic      r_out_stall;
    t_out_beat w_out_data;
    int        errors;
    int        pending;
    int        results;
    int        rejects;
    int        sent;
    bit        quiet;
    bit        hold_go;
    int        idle_cycles;

    running_median_two_heaps #(.CAPACITY(CAPACITY)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_in_valid),
        .o_in_stall  (w_in_stall),
        .i_in_data   (r_in_data),
        .o_out_valid (w_out_valid),
        .i_out_stall (r_out_stall),
        .o_out_data  (w_out_data)
    );

    running_median_two_heaps_chk #(.CAPACITY(CAPACITY)) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_in_valid),
        .i_in_stall  (w_in_stall),
        .i_in_data   (r_in_data),
        .i_out_valid (w_out_valid),
        .i_out_stall (r_out_stall),
        .i_out_data  (w_out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_rejects   (rejects)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int burst;
        int held;
        bit hold_done;
        burst     = 0;
        held      = 0;
        hold_done = 0;
        r_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                held++;
                if (held >= HOLD_LEN) hold_done = 1;
                r_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                r_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(0, 8);
                r_out_stall <= 1'b1;
            end else begin
                r_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((r_in_valid && !w_in_stall) || (w_out_valid && !r_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Offer one beat, with an optional idle burst before it; return on accept.
    task automatic send_beat(input logic signed [SAMPLE_WIDTH-1:0] s, input logic st);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            r_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r_in_valid          <= 1'b1;
        r_in_data.sample    <= s;
        r_in_data.start_new <= st;
        @(posedge i_clk);
        while (w_in_stall) @(posedge i_clk);
        sent++;
        if (sent >= QUIET_FROM) quiet = 1;
        if (sent == 300) hold_go = 1;
    endtask

    // Mix of extremes, a narrow band that makes ties, and the full range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2:    return SAMPLE_WIDTH'($signed($urandom_range(0, 14)) - 7);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    initial begin
        int seg;
        r_in_valid = 1'b0;
        r_in_data  = '0;
        i_rst_n    = 1'b0;
        sent       = 0;
        quiet      = 0;
        hold_go    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, ties, even and odd counts, restart.
        send_beat(16'sh7fff, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7fff, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sh0001, 1'b0);
        send_beat(16'sh0001, 1'b0);
        send_beat(16'sh0001, 1'b0);
        send_beat(16'sh8000, 1'b1);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7fff, 1'b1);
        send_beat(16'sh7fff, 1'b0);
        send_beat(16'sh5555, 1'b0);
        send_beat(-16'sh5556, 1'b0);
        send_beat(16'sh0100, 1'b0);
        send_beat(-16'sh0100, 1'b0);

        // Fill past capacity, then restart while full.
        send_beat(pick_sample(), 1'b1);
        repeat (CAPACITY + 12) send_beat(pick_sample(), 1'b0);
        send_beat(pick_sample(), 1'b1);

        // Short streams with random content and occasional stray restarts.
        while (sent < ITEM_TOTAL) begin
            seg = $urandom_range(1, 40);
            repeat (seg) send_beat(pick_sample(), $urandom_range(0, 29) == 0);
            send_beat(pick_sample(), 1'b1);
        end

        // Drain, then allow the block's latency before the verdict.
        @(posedge i_clk);
        r_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("covered %0d samples, %0d results checked, %0d full-store rejects",
                 sent, results, rejects);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
design/rmth_pkg.sv
design/running_median_two_heaps.sv
verif/running_median_two_heaps_chk.sv
verif/running_median_two_heaps_tb.sv
